// File: rtl/core/sbph_pkg.sv
// ----------------------------------------------------------------------------
// sbph_pkg
// shared types, constants and the band divisor table for the band peak hold
// ----------------------------------------------------------------------------
package sbph_pkg;

  localparam int NUM_BANDS_DEF     = 20;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int BIN_W   = 16;
  localparam int BAND_W  = 5;
  localparam int SUM_W   = 21;
  localparam int DIV_W   = 12;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int BASE_DIV  = 2048;
  localparam int DIV_STEP  = 90;
  localparam int BASE_BINS = 3;

  localparam int HOLD_FRAMES_RST = 20;
  localparam int LEVEL_LIMIT_RST = 110;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT = 2'd1;

  typedef struct packed {
    logic [BIN_W-1:0] bin_value;
    logic             frame_start;
  } bin_item_t;

  typedef struct packed {
    logic [BAND_W-1:0] band_number;
    logic [OUT_W-1:0]  bar_level;
    logic [OUT_W-1:0]  hold_level;
    logic              last_band;
  } band_item_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic smooth;
    logic finish;
  } sbph_cmd_t;

  typedef struct packed {
    logic band_complete;
    logic div_done;
    logic out_free;
  } sbph_status_t;

  function automatic logic [DIV_W-1:0] divisor_of(input logic [BAND_W-1:0] band);
    int d;
    d = BASE_DIV - DIV_STEP * int'(band);
    return DIV_W'(d);
  endfunction

endpackage

// File: rtl/core/spectrum_band_peak_hold.sv
// ----------------------------------------------------------------------------
// spectrum_band_peak_hold
// spectrum bands from fft bins, with smoothed bar level and peak hold
// ----------------------------------------------------------------------------
// bin channel: one fft magnitude bin per transfer, frame_start on the first
// bin of a frame. band b takes the next 3+b bins; bins after the last band
// are dropped until the next frame start.
// band channel: one result per completed band, last_band on the final one.
// cfg channel: index 0 hold_frames, index 1 level_limit, ready outside reset.
// sequence: a bin that does not close a band is taken at once. the bin that
// closes a band is followed by the shift and subtract divider, which builds
// the quotient bit by bit, then by smoothing and the peak update, and no bin
// is taken until the result is loaded into the output register.
// a stalled result is held in the output register; bins keep being taken
// until the next band closes, then the block waits for the register.
// reset: limits return to 20 and 110, all band state clears, and the block
// ignores bins until a frame start. bins and writes are held off in reset.
// ----------------------------------------------------------------------------
module spectrum_band_peak_hold
  import sbph_pkg::*;
#(
  parameter int NUM_BANDS     = NUM_BANDS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 bin_valid,
  output logic                 bin_stall,
  input  bin_item_t            bin_data,
  output logic                 band_valid,
  input  logic                 band_stall,
  output band_item_t           band_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sbph_cmd_t    cmd;
  sbph_status_t status;

  assign cfg_ready = !rst;

  sbph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sbph_datapath #(
    .NUM_BANDS     (NUM_BANDS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .bin_data   (bin_data),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .band_valid (band_valid),
    .band_stall (band_stall),
    .band_data  (band_data)
  );

endmodule

// File: rtl/core/sbph_ctrl.sv
// ----------------------------------------------------------------------------
// sbph_ctrl
// sequencer: bin accumulation, band divide, smoothing and peak update steps
// ----------------------------------------------------------------------------
module sbph_ctrl
  import sbph_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         bin_valid,
  output logic         bin_stall,
  input  sbph_status_t status,
  output sbph_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_ACCUM  = 4'b0001,
    S_DIV    = 4'b0010,
    S_SMOOTH = 4'b0100,
    S_PEAK   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    bin_stall  = 1'b1;
    unique case (state)
      S_ACCUM: begin
        bin_stall = rst;
        cmd.take  = bin_valid && !rst;
        if (bin_valid && status.band_complete) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = S_PEAK;
      end
      S_PEAK: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_ACCUM;
        end
      end
      default: begin
        state_next = S_ACCUM;
      end
    endcase
  end

  // band completion always leads into the divide
  a_complete_to_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.band_complete) |=> (state == S_DIV))
    else $error("band completion did not start divide");

  // nothing is taken from the input while a band is being finished
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_ACCUM) |-> (bin_stall && !cmd.take))
    else $error("transfer taken while busy");

endmodule

// File: rtl/core/sbph_datapath.sv
// ----------------------------------------------------------------------------
// sbph_datapath
// band accumulator, shift-subtract divider, smoothing, peak hold and output
// ----------------------------------------------------------------------------
module sbph_datapath
  import sbph_pkg::*;
#(
  parameter int NUM_BANDS     = NUM_BANDS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bin_item_t            bin_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  sbph_cmd_t            cmd,
  output sbph_status_t         status,
  output logic                 band_valid,
  input  logic                 band_stall,
  output band_item_t           band_data
);

  localparam int LVL_W  = CFG_W + FRACTION_BITS;
  localparam int DVD_W  = SUM_W + FRACTION_BITS;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam int IDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  logic [CFG_W-1:0] hold_frames;
  logic [CFG_W-1:0] level_limit;

  logic [BAND_W-1:0] current_band;
  logic [BAND_W-1:0] bin_in_band;
  logic [SUM_W-1:0]  band_sum;
  logic [BAND_W-1:0] work_band;

  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] divisor;
  logic [CNT_W-1:0] div_cnt;

  logic [LVL_W-1:0] level;

  logic [CFG_W-1:0] smoothed_whole [NUM_BANDS];
  logic [LVL_W-1:0] held_peak      [NUM_BANDS];
  logic [CFG_W-1:0] hold_left      [NUM_BANDS];

  logic complete_now, div_last, out_free;

  assign status = '{band_complete: complete_now, div_done: div_last, out_free: out_free};

  // accumulation
  logic [BAND_W-1:0] eff_band, eff_cnt, cnt_next;
  logic [SUM_W-1:0]  eff_sum, sum_next;
  logic              active;

  always_comb begin
    eff_band = bin_data.frame_start ? '0 : current_band;
    eff_cnt  = bin_data.frame_start ? '0 : bin_in_band;
    eff_sum  = bin_data.frame_start ? '0 : band_sum;
    cnt_next = eff_cnt + BAND_W'(1);
    sum_next = eff_sum + SUM_W'(bin_data.bin_value);
    active   = eff_band < BAND_W'(NUM_BANDS);
    complete_now = active && (cnt_next >= BAND_W'(BASE_BINS) + eff_band);
  end

  // divider step
  logic [DIV_W:0] trial;
  logic           ge;

  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    ge    = trial >= {1'b0, divisor};
    div_last = (div_cnt == '0);
  end

  // clamp and smoothing
  logic [IDX_W-1:0] idx;
  logic [LVL_W-1:0] lim, clamped, old;
  logic [LVL_W+1:0] mix;
  logic [LVL_W-1:0] level_new;

  always_comb begin
    idx     = work_band[IDX_W-1:0];
    lim     = {level_limit, {FRACTION_BITS{1'b0}}};
    clamped = (quo > DVD_W'(lim)) ? lim : quo[LVL_W-1:0];
    old     = {smoothed_whole[idx], {FRACTION_BITS{1'b0}}};
    mix     = {2'b00, clamped} + {2'b00, old} + {1'b0, old, 1'b0};
    level_new = (clamped < old) ? mix[LVL_W+1:2] : clamped;
  end

  // peak hold
  localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << FRACTION_BITS;
  logic [LVL_W-1:0] pk1, pk2;
  logic [CFG_W-1:0] lf1, lf2;
  logic [31:0]      bar_ext, hold_ext;

  always_comb begin
    pk1 = held_peak[idx];
    lf1 = hold_left[idx];
    if (level > pk1) begin
      pk1 = level;
      lf1 = hold_frames;
    end
    lf2 = (lf1 != '0) ? lf1 - CFG_W'(1) : '0;
    pk2 = pk1;
    if (lf2 == '0) begin
      pk2 = (pk1 >= ONE) ? pk1 - ONE : '0;
    end
    bar_ext  = 32'(level);
    hold_ext = 32'(pk2);
    out_free = !band_valid || !band_stall;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames <= CFG_W'(HOLD_FRAMES_RST);
      level_limit <= CFG_W'(LEVEL_LIMIT_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HOLD_FRAMES: hold_frames <= cfg_data;
        REG_LEVEL_LIMIT: level_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // band accumulation and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_band <= BAND_W'(NUM_BANDS);
      bin_in_band  <= '0;
      band_sum     <= '0;
      band_valid   <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        smoothed_whole[b] <= '0;
        held_peak[b]      <= '0;
        hold_left[b]      <= '0;
      end
    end else begin
      if (cmd.take && active) begin
        if (complete_now) begin
          current_band <= eff_band + BAND_W'(1);
          bin_in_band  <= '0;
          band_sum     <= '0;
        end else begin
          current_band <= eff_band;
          bin_in_band  <= cnt_next;
          band_sum     <= sum_next;
        end
      end
      if (cmd.smooth) begin
        smoothed_whole[idx] <= level_new[LVL_W-1:FRACTION_BITS];
      end
      if (cmd.finish) begin
        held_peak[idx] <= pk2;
        hold_left[idx] <= lf2;
        band_valid     <= 1'b1;
      end else if (!band_stall) begin
        band_valid <= 1'b0;
      end
    end
  end

  // divider and payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && complete_now) begin
      work_band <= eff_band;
      quo       <= {sum_next, {FRACTION_BITS{1'b0}}};
      rem       <= '0;
      divisor   <= divisor_of(eff_band);
      div_cnt   <= CNT_W'(DVD_W - 1);
    end else if (cmd.div_step) begin
      quo     <= {quo[DVD_W-2:0], ge};
      rem     <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      div_cnt <= div_cnt - CNT_W'(1);
    end
    if (cmd.smooth) begin
      level <= level_new;
    end
    if (cmd.finish) begin
      band_data.band_number <= work_band;
      band_data.bar_level   <= (bar_ext > 32'hFFFF) ? 16'hFFFF : bar_ext[OUT_W-1:0];
      band_data.hold_level  <= (hold_ext > 32'hFFFF) ? 16'hFFFF : hold_ext[OUT_W-1:0];
      band_data.last_band   <= (work_band == BAND_W'(NUM_BANDS - 1));
    end
  end

  // a result is only loaded when the output register can take it
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded over a pending transfer");

  // smoothing follows the last divide step
  a_smooth_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.smooth |-> $past(cmd.div_step && status.div_done))
    else $error("smoothing without a finished divide");

  // a finished band always leaves a valid result behind
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> band_valid)
    else $error("result lost after finish");

endmodule

// File: tb/tb_spectrum_band_peak_hold.sv
// ----------------------------------------------------------------------------
// tb_spectrum_band_peak_hold
// self-checking bench for the spectrum band peak hold block
// ----------------------------------------------------------------------------
// fft bins are pushed through the bin channel as whole frames, short frames
// and broken frames with random content. a behavioural predictor works out
// every band result, and each band transfer is compared field by field with
// the oldest prediction. the limits are rewritten between phases while the
// block is quiet, and the phases vary sender gaps and receiver stalls,
// including one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_spectrum_band_peak_hold;
  import sbph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS        = NUM_BANDS_DEF;
  localparam int FRAC         = FRACTION_BITS_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BINS   = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 bin_valid = 1'b0;
  logic                 bin_stall;
  bin_item_t            bin_data = '0;
  logic                 band_valid;
  logic                 band_stall = 1'b0;
  band_item_t           band_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [CFG_W-1:0] hold_frames_q = CFG_W'(HOLD_FRAMES_RST);
  logic [CFG_W-1:0] level_limit_q = CFG_W'(LEVEL_LIMIT_RST);
  logic [31:0]      acc_sum = '0;
  int               acc_count = 0;
  int               acc_band = BANDS;
  logic [7:0]       smooth_q [BANDS];
  logic [31:0]      peak_q [BANDS];
  logic [7:0]       peak_wait [BANDS];
  band_item_t       pending_bands [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_off_req = 0;
  int hold_off_cnt = 0;
  int live_bins = 0;
  int mismatches = 0;
  int cycle_count = 0;

  spectrum_band_peak_hold #(
    .NUM_BANDS     (BANDS),
    .FRACTION_BITS (FRAC)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .bin_valid  (bin_valid),
    .bin_stall  (bin_stall),
    .bin_data   (bin_data),
    .band_valid (band_valid),
    .band_stall (band_stall),
    .band_data  (band_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_spectrum_band_peak_hold: FAIL");
      $finish;
    end
  end

  function automatic logic [OUT_W-1:0] clip16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // band level and peak for one accepted bin
  task automatic accumulate_bin(input logic [BIN_W-1:0] value, input logic start);
    logic [31:0] level, old, lim, divisor, one;
    int b;
    band_item_t r;
    if (start) begin
      acc_band = 0;
      acc_count = 0;
      acc_sum = '0;
    end
    if (acc_band >= BANDS) return;
    live_bins++;
    b = acc_band;
    acc_sum += 32'(value);
    acc_count++;
    if (acc_count < BASE_BINS + b) return;
    divisor = 32'(BASE_DIV - DIV_STEP * b);
    level = (acc_sum << FRAC) / divisor;
    lim = 32'(level_limit_q) << FRAC;
    if (level > lim) level = lim;
    old = 32'(smooth_q[b]) << FRAC;
    if (level < old) level = (level + 3 * old) >> 2;
    smooth_q[b] = 8'(level >> FRAC);
    if (level > peak_q[b]) begin
      peak_q[b] = level;
      peak_wait[b] = hold_frames_q;
    end
    if (peak_wait[b] != 0) peak_wait[b]--;
    if (peak_wait[b] == 0) begin
      one = 32'(1) << FRAC;
      peak_q[b] = (peak_q[b] >= one) ? peak_q[b] - one : '0;
    end
    r.band_number = BAND_W'(b);
    r.bar_level   = clip16(level);
    r.hold_level  = clip16(peak_q[b]);
    r.last_band   = (b == BANDS - 1);
    pending_bands.push_back(r);
    acc_band++;
    acc_count = 0;
    acc_sum = '0;
  endtask

  task automatic send_bin(input logic [BIN_W-1:0] value, input logic start);
    if ($urandom_range(99) < tx_idle_pct) begin
      bin_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    bin_valid <= 1'b1;
    bin_data <= '{bin_value: value, frame_start: start};
    do @(posedge clk); while (bin_stall);
    accumulate_bin(value, start);
  endtask

  task automatic wait_drained();
    bin_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HOLD_FRAMES;
    cfg_data <= hold;
    do @(posedge clk); while (!cfg_ready);
    hold_frames_q = hold;
    cfg_index <= REG_LEVEL_LIMIT;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    level_limit_q = limit;
    cfg_valid <= 1'b0;
  endtask

  // bands 0..last with random magnitudes, sometimes broken off or padded
  task automatic send_frame(input bit whole);
    int last, k, extra;
    logic [31:0] mask;
    logic [BIN_W-1:0] v;
    last = (whole || $urandom_range(99) < 35) ? BANDS - 1 : $urandom_range(BANDS - 1);
    for (int b = 0; b <= last; b++) begin
      k = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(16, 10);
      mask = (32'h1 << k) - 1;
      for (int i = 0; i < BASE_BINS + b; i++) begin
        v = ($urandom_range(15) == 0) ? 16'hFFFF : BIN_W'($urandom & mask);
        send_bin(v, b == 0 && i == 0);
      end
    end
    if (!whole && $urandom_range(99) < 20) begin
      extra = (last == BANDS - 1) ? $urandom_range(8, 1) : $urandom_range(last + 3, 1);
      for (int i = 0; i < extra; i++) send_bin(BIN_W'($urandom), 1'b0);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] limit,
                           input int tx_pct, input int rx_pct);
    int target;
    wait_drained();
    set_limits(hold, limit);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    target = live_bins + PHASE_BINS;
    while (live_bins < target) send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_idle_bins();
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'hA5A5, 1'b0);
  endtask

  task automatic test_bin_extremes();
    send_bin(16'hFFFF, 1'b1);
    repeat (2) send_bin(16'hFFFF, 1'b0);
    repeat (4) send_bin(16'hFFFF, 1'b0);
    repeat (5) send_bin(16'h0000, 1'b0);
  endtask

  task automatic test_restart_mid_frame();
    repeat (2) send_bin(16'h1234, 1'b0);
    send_bin(16'h0000, 1'b1);
    repeat (2) send_bin(16'h0000, 1'b0);
    repeat (2) send_bin(16'h8001, 1'b0);
    send_bin(16'h5A5A, 1'b1);
    repeat (2) send_bin(16'h5A5A, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_off_req = 600;
    send_frame(1'b1);
    wait_drained();
    send_frame(1'b1);
  endtask

  task automatic test_zero_hold_full_scale();
    run_phase(8'd0, 8'd255, 0, 0);
  endtask

  task automatic test_long_hold_sender_gaps();
    run_phase(8'd255, 8'd40, 71, 0);
  endtask

  task automatic test_zero_limit_receiver_stall();
    run_phase(8'd3, 8'd0, 0, 71);
  endtask

  task automatic test_short_hold_both_idle();
    run_phase(8'd1, 8'd110, 29, 29);
  endtask

  task automatic test_default_hold_no_idle();
    run_phase(8'd20, 8'd200, 0, 0);
  endtask

  // receiver stall, with a counted hold-off on request
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_off_cnt = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_cnt != 0) begin
      band_stall <= 1'b1;
      hold_off_cnt--;
    end else begin
      band_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic void note_mismatch(string field, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 10)
      $display("band transfer mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin : check_bands
    band_item_t want;
    if (!rst && band_valid && !band_stall) begin
      if (pending_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected band transfer: %p", band_data);
      end else begin
        want = pending_bands.pop_front();
        if (band_data.band_number !== want.band_number)
          note_mismatch("band_number", band_data.band_number, want.band_number);
        if (band_data.bar_level !== want.bar_level)
          note_mismatch("bar_level", band_data.bar_level, want.bar_level);
        if (band_data.hold_level !== want.hold_level)
          note_mismatch("hold_level", band_data.hold_level, want.hold_level);
        if (band_data.last_band !== want.last_band)
          note_mismatch("last_band", band_data.last_band, want.last_band);
      end
    end
  end

  initial begin
    for (int b = 0; b < BANDS; b++) begin
      smooth_q[b] = '0;
      peak_q[b] = '0;
      peak_wait[b] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_bins();
    test_bin_extremes();
    test_restart_mid_frame();
    test_backpressure();
    test_zero_hold_full_scale();
    test_long_hold_sender_gaps();
    test_zero_limit_receiver_stall();
    test_short_hold_both_idle();
    test_default_hold_no_idle();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_spectrum_band_peak_hold: PASS");
    end else begin
      $display("tb_spectrum_band_peak_hold: FAIL");
    end
    $finish;
  end

endmodule
